// File: rtl/joystick_zone_sequence_matcher_unit_macros.svh
// Assertion macros for the joystick zone sequence matcher.
// Used by the top level; expects clk and rst_n in scope.
`ifndef JOYSTICK_ZONE_SEQUENCE_MATCHER_UNIT_MACROS_SVH
`define JOYSTICK_ZONE_SEQUENCE_MATCHER_UNIT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define JZSM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Plain invariant checked on every clock edge outside reset.
`define JZSM_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

`endif

// File: rtl/jzsm_pkg.sv
// Package for the joystick zone sequence matcher: payload types, zone codes,
// register indexes, the sequence pattern table and small decode functions. No dependencies.
`default_nettype none

package jzsm_pkg;

  typedef logic [3:0] zone_t;
  typedef logic [1:0] band_t;
  typedef logic [2:0] cfg_idx_t;

  // Zone codes.
  localparam zone_t ZONE_NEUTRAL = 4'd0;
  localparam zone_t ZONE_N       = 4'd1;
  localparam zone_t ZONE_NE      = 4'd2;
  localparam zone_t ZONE_E       = 4'd3;
  localparam zone_t ZONE_SE      = 4'd4;
  localparam zone_t ZONE_S       = 4'd5;
  localparam zone_t ZONE_SW      = 4'd6;
  localparam zone_t ZONE_W       = 4'd7;
  localparam zone_t ZONE_NW      = 4'd8;

  // Axis band codes.
  localparam band_t BAND_LOW  = 2'd0;
  localparam band_t BAND_MID  = 2'd1;
  localparam band_t BAND_HIGH = 2'd2;
  localparam band_t BAND_DEAD = 2'd3;

  // Configuration register indexes.
  localparam cfg_idx_t REG_XY_THRESHOLD    = 3'd0;
  localparam cfg_idx_t REG_HYSTERESIS      = 3'd1;
  localparam cfg_idx_t REG_ENABLE_CARDINAL = 3'd2;
  localparam cfg_idx_t REG_ENABLE_DIAGONAL = 3'd3;
  localparam cfg_idx_t REG_SPECIAL_MASK    = 3'd4;

  localparam logic [7:0] STICK_CENTER = 8'd128;
  localparam int         NUM_PATTERNS = 24;
  localparam int         GROUP_SIZE   = 8;

  // Pattern table, oldest entry first; a neutral entry matches any zone.
  localparam zone_t PATTERNS [NUM_PATTERNS][3] = '{
    '{ZONE_NEUTRAL, ZONE_N,  ZONE_NE}, '{ZONE_NEUTRAL, ZONE_E,  ZONE_NE},
    '{ZONE_NEUTRAL, ZONE_E,  ZONE_SE}, '{ZONE_NEUTRAL, ZONE_S,  ZONE_SE},
    '{ZONE_NEUTRAL, ZONE_N,  ZONE_NW}, '{ZONE_NEUTRAL, ZONE_W,  ZONE_NW},
    '{ZONE_NEUTRAL, ZONE_W,  ZONE_SW}, '{ZONE_NEUTRAL, ZONE_S,  ZONE_SW},
    '{ZONE_NEUTRAL, ZONE_NE, ZONE_N }, '{ZONE_NEUTRAL, ZONE_NE, ZONE_E },
    '{ZONE_NEUTRAL, ZONE_SE, ZONE_E }, '{ZONE_NEUTRAL, ZONE_SE, ZONE_S },
    '{ZONE_NEUTRAL, ZONE_NW, ZONE_N }, '{ZONE_NEUTRAL, ZONE_NW, ZONE_W },
    '{ZONE_NEUTRAL, ZONE_SW, ZONE_W }, '{ZONE_NEUTRAL, ZONE_SW, ZONE_S },
    '{ZONE_E, ZONE_NE, ZONE_N}, '{ZONE_E, ZONE_SE, ZONE_S},
    '{ZONE_W, ZONE_NW, ZONE_N}, '{ZONE_W, ZONE_SW, ZONE_S},
    '{ZONE_N, ZONE_NE, ZONE_E}, '{ZONE_S, ZONE_SE, ZONE_E},
    '{ZONE_N, ZONE_NW, ZONE_W}, '{ZONE_S, ZONE_SW, ZONE_W}
  };

  typedef struct packed {
    logic [7:0] stick_x;
    logic [7:0] stick_y;
  } in_t;

  typedef struct packed {
    logic       zone_hit;
    zone_t      zone;
    logic       history_pushed;
    logic [4:0] command;
  } out_t;

  // Sort one axis value against the four borders, in order.
  function automatic band_t axis_band(input logic [7:0] v, input logic [7:0] lo_l,
                                      input logic [7:0] lo_h, input logic [7:0] hi_l,
                                      input logic [7:0] hi_h);
    band_t b;
    if (v < lo_l)      b = BAND_LOW;
    else if (v < lo_h) b = BAND_DEAD;
    else if (v < hi_l) b = BAND_MID;
    else if (v < hi_h) b = BAND_DEAD;
    else               b = BAND_HIGH;
    return b;
  endfunction

  // Map the x and y bands to a grid zone; low x is West, low y is South.
  function automatic zone_t grid_zone(input band_t bx, input band_t by);
    zone_t z;
    case ({bx, by})
      {BAND_LOW,  BAND_LOW }: z = ZONE_SW;
      {BAND_LOW,  BAND_MID }: z = ZONE_W;
      {BAND_LOW,  BAND_HIGH}: z = ZONE_NW;
      {BAND_MID,  BAND_LOW }: z = ZONE_S;
      {BAND_MID,  BAND_MID }: z = ZONE_NEUTRAL;
      {BAND_MID,  BAND_HIGH}: z = ZONE_N;
      {BAND_HIGH, BAND_LOW }: z = ZONE_SE;
      {BAND_HIGH, BAND_MID }: z = ZONE_E;
      {BAND_HIGH, BAND_HIGH}: z = ZONE_NE;
      default:                z = ZONE_NEUTRAL;
    endcase
    return z;
  endfunction

endpackage

`default_nettype wire

// File: rtl/joystick_zone_sequence_matcher_unit.sv
// Top level of the joystick zone sequence matcher: input register, zone decode,
// history update, pattern match and result register. Uses jzsm_pkg and the macros header.
`default_nettype none

// One result per stick sample. A sample passes through an input register and
// a result register, and a new sample can be taken in every cycle while the
// result side keeps up. Zone decode, the three-deep history update and the
// match against the 24 sequences all sit in the single logic stage between
// those two registers. Configuration writes are always ready and take effect
// on the next cycle; indexes beyond the last register are ignored.
`include "joystick_zone_sequence_matcher_unit_macros.svh"

module joystick_zone_sequence_matcher_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire jzsm_pkg::in_t     in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output jzsm_pkg::out_t         out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire jzsm_pkg::cfg_idx_t cfg_index,
  input  wire logic [7:0]        cfg_data
);

  // Configuration registers.
  logic [6:0] xy_threshold_r;
  logic [7:0] hysteresis_r;
  logic       enable_cardinal_r;
  logic       enable_diagonal_r;
  logic [7:0] special_mask_r;

  // Pipeline registers.
  logic           s1_valid_r, s1_valid_nxt;
  jzsm_pkg::in_t  s1_data_r;
  logic           out_valid_r, out_valid_nxt;
  jzsm_pkg::out_t out_data_r, out_data_nxt;
  jzsm_pkg::zone_t hist_r   [3];
  jzsm_pkg::zone_t hist_nxt [3];

  // Handshake control.
  logic out_free;
  logic s1_move;
  logic in_take;

  // Datapath.
  logic [7:0] lo_l, lo_h, hi_l, hi_h;
  logic [6:0] half_hyst;
  jzsm_pkg::band_t band_x, band_y;
  jzsm_pkg::zone_t zone_now;
  logic            hit;
  logic            push;
  logic [jzsm_pkg::NUM_PATTERNS-1:0] match_vec;
  logic [4:0]      command;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The input register moves on whenever the result register is empty or drained.
  assign out_free = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = in_take ? 1'b1 : (s1_move ? 1'b0 : s1_valid_r);
    out_valid_nxt = out_free ? s1_move : 1'b1;
  end

  // Borders, wrapped modulo 256.
  always_comb begin
    half_hyst = hysteresis_r[7:1];
    lo_l = jzsm_pkg::STICK_CENTER - {1'b0, xy_threshold_r} - {1'b0, half_hyst};
    lo_h = jzsm_pkg::STICK_CENTER - {1'b0, xy_threshold_r} + {1'b0, half_hyst};
    hi_l = jzsm_pkg::STICK_CENTER + {1'b0, xy_threshold_r} - {1'b0, half_hyst};
    hi_h = jzsm_pkg::STICK_CENTER + {1'b0, xy_threshold_r} + {1'b0, half_hyst};
  end

  // Zone decode and history update.
  always_comb begin
    band_x   = jzsm_pkg::axis_band(s1_data_r.stick_x, lo_l, lo_h, hi_l, hi_h);
    band_y   = jzsm_pkg::axis_band(s1_data_r.stick_y, lo_l, lo_h, hi_l, hi_h);
    hit      = (band_x != jzsm_pkg::BAND_DEAD) && (band_y != jzsm_pkg::BAND_DEAD);
    zone_now = hit ? jzsm_pkg::grid_zone(band_x, band_y) : jzsm_pkg::ZONE_NEUTRAL;
    push     = hit && (zone_now != hist_r[2]);
    if (push) begin
      hist_nxt[0] = hist_r[1];
      hist_nxt[1] = hist_r[2];
      hist_nxt[2] = zone_now;
    end else begin
      hist_nxt[0] = hist_r[0];
      hist_nxt[1] = hist_r[1];
      hist_nxt[2] = hist_r[2];
    end
  end

  // Compare every pattern against the updated history, gated by its enable.
  always_comb begin
    for (int p = 0; p < jzsm_pkg::NUM_PATTERNS; p++) begin
      logic en;
      logic ok;
      if (p < jzsm_pkg::GROUP_SIZE)          en = enable_cardinal_r;
      else if (p < 2 * jzsm_pkg::GROUP_SIZE) en = enable_diagonal_r;
      else                                   en = special_mask_r[p - 2 * jzsm_pkg::GROUP_SIZE];
      ok = 1'b1;
      for (int i = 0; i < 3; i++) begin
        if (jzsm_pkg::PATTERNS[p][i] != jzsm_pkg::ZONE_NEUTRAL &&
            jzsm_pkg::PATTERNS[p][i] != hist_nxt[i]) begin
          ok = 1'b0;
        end
      end
      match_vec[p] = en && ok;
    end
  end

  // Highest matching pattern wins.
  always_comb begin
    command = 5'd0;
    for (int p = 0; p < jzsm_pkg::NUM_PATTERNS; p++) begin
      if (match_vec[p]) command = 5'(p + 1);
    end
  end

  always_comb begin
    out_data_nxt.zone_hit       = hit;
    out_data_nxt.zone           = zone_now;
    out_data_nxt.history_pushed = push;
    out_data_nxt.command        = command;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r        <= 1'b0;
      out_valid_r       <= 1'b0;
      xy_threshold_r    <= 7'd64;
      hysteresis_r      <= 8'd16;
      enable_cardinal_r <= 1'b1;
      enable_diagonal_r <= 1'b1;
      special_mask_r    <= 8'hFF;
      hist_r[0]         <= jzsm_pkg::ZONE_NEUTRAL;
      hist_r[1]         <= jzsm_pkg::ZONE_NEUTRAL;
      hist_r[2]         <= jzsm_pkg::ZONE_NEUTRAL;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_move) begin
        hist_r[0] <= hist_nxt[0];
        hist_r[1] <= hist_nxt[1];
        hist_r[2] <= hist_nxt[2];
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          jzsm_pkg::REG_XY_THRESHOLD:    xy_threshold_r    <= cfg_data[6:0];
          jzsm_pkg::REG_HYSTERESIS:      hysteresis_r      <= cfg_data;
          jzsm_pkg::REG_ENABLE_CARDINAL: enable_cardinal_r <= cfg_data[0];
          jzsm_pkg::REG_ENABLE_DIAGONAL: enable_diagonal_r <= cfg_data[0];
          jzsm_pkg::REG_SPECIAL_MASK:    special_mask_r    <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) s1_data_r <= in_data;
    if (s1_move) out_data_r <= out_data_nxt;
  end

  // Checks.
  `JZSM_ASSERT_IMP(a_push_needs_hit, out_valid_r && out_data_r.history_pushed,
                   out_data_r.zone_hit, "history pushed without a zone hit")
  `JZSM_ASSERT_IMP(a_dead_is_neutral, out_valid_r && !out_data_r.zone_hit,
                   out_data_r.zone == jzsm_pkg::ZONE_NEUTRAL, "dead band with nonzero zone")
  `JZSM_ASSERT_IMP(a_push_lands, $past(s1_move) && out_data_r.history_pushed,
                   hist_r[2] == out_data_r.zone, "pushed zone not at history head")
  `JZSM_ASSERT_ALWAYS(a_hist_distinct, hist_r[1] != hist_r[2] ||
                      hist_r[2] == jzsm_pkg::ZONE_NEUTRAL, "history repeats newest zone")

endmodule

`default_nettype wire

// File: verif/tb_joystick_zone_sequence_matcher_unit.sv
// Self-checking testbench for the joystick zone sequence matcher unit.
// Drives stick samples and register writes, predicts zone, history push and command.
// Depends on jzsm_pkg and the joystick_zone_sequence_matcher_unit RTL only.

module tb_joystick_zone_sequence_matcher_unit;
  import jzsm_pkg::*;

  // Indexes beyond the last register; writes to them must change nothing.
  localparam cfg_idx_t REG_SPARE_LOW  = 3'd5;
  localparam cfg_idx_t REG_SPARE_HIGH = 3'd7;

  localparam logic [4:0] NO_COMMAND     = 5'd0;
  localparam logic [7:0] STICK_MID      = 8'd128;
  localparam int         GESTURE_COUNT  = 24;
  localparam int         GROUP_LEN      = 8;
  localparam int         PHASE_COUNT    = 8;
  localparam int         PHASE_ITEMS    = 110;
  localparam int         SETTLE_CYCLES  = 4;
  localparam int         LONG_HOLD_CYCLES = 50;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         REPORT_LIMIT   = 10;

  typedef enum logic [1:0] {SEG_LOW, SEG_MID, SEG_HIGH, SEG_DEAD} segment_e;
  typedef enum logic {STEP_SAMPLE, STEP_WRITE} step_e;

  typedef struct packed {
    step_e      kind;
    cfg_idx_t   reg_index;
    logic [7:0] reg_value;
    in_t        sample;
    logic       typed;
    out_t       result;
  } plan_row_t;

  // Zone of each x segment (outer index) and y segment (inner index).
  localparam zone_t ZONE_GRID [3][3] = '{
    '{ZONE_SW, ZONE_W,       ZONE_NW},
    '{ZONE_S,  ZONE_NEUTRAL, ZONE_N },
    '{ZONE_SE, ZONE_E,       ZONE_NE}
  };

  // The 24 gestures, oldest zone first; a neutral zone matches anything.
  localparam zone_t GESTURE_SEQ [GESTURE_COUNT][3] = '{
    '{ZONE_NEUTRAL, ZONE_N,  ZONE_NE}, '{ZONE_NEUTRAL, ZONE_E,  ZONE_NE},
    '{ZONE_NEUTRAL, ZONE_E,  ZONE_SE}, '{ZONE_NEUTRAL, ZONE_S,  ZONE_SE},
    '{ZONE_NEUTRAL, ZONE_N,  ZONE_NW}, '{ZONE_NEUTRAL, ZONE_W,  ZONE_NW},
    '{ZONE_NEUTRAL, ZONE_W,  ZONE_SW}, '{ZONE_NEUTRAL, ZONE_S,  ZONE_SW},
    '{ZONE_NEUTRAL, ZONE_NE, ZONE_N }, '{ZONE_NEUTRAL, ZONE_NE, ZONE_E },
    '{ZONE_NEUTRAL, ZONE_SE, ZONE_E }, '{ZONE_NEUTRAL, ZONE_SE, ZONE_S },
    '{ZONE_NEUTRAL, ZONE_NW, ZONE_N }, '{ZONE_NEUTRAL, ZONE_NW, ZONE_W },
    '{ZONE_NEUTRAL, ZONE_SW, ZONE_W }, '{ZONE_NEUTRAL, ZONE_SW, ZONE_S },
    '{ZONE_E, ZONE_NE, ZONE_N}, '{ZONE_E, ZONE_SE, ZONE_S},
    '{ZONE_W, ZONE_NW, ZONE_N}, '{ZONE_W, ZONE_SW, ZONE_S},
    '{ZONE_N, ZONE_NE, ZONE_E}, '{ZONE_S, ZONE_SE, ZONE_E},
    '{ZONE_N, ZONE_NW, ZONE_W}, '{ZONE_S, ZONE_SW, ZONE_W}
  };

  localparam out_t UNTYPED = '0;
  localparam int   PLAN_ROWS = 35;

  // Directed plan. Rows with typed set carry a result read straight off the
  // reset borders (56, 72, 184, 200) and the empty history.
  localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
    // Centre, dead band, far corner, then the same corner again.
    '{STEP_SAMPLE, REG_XY_THRESHOLD, 8'h00, '{8'd128, 8'd128}, 1'b1,
      '{1'b1, ZONE_NEUTRAL, 1'b0, NO_COMMAND}},
    '{STEP_SAMPLE, REG_XY_THRESHOLD, 8'h00, '{8'd56, 8'd128}, 1'b1,
      '{1'b0, ZONE_NEUTRAL, 1'b0, NO_COMMAND}},
    '{STEP_SAMPLE, REG_XY_THRESHOLD, 8'h00, '{8'd255, 8'd255}, 1'b1,
      '{1'b1, ZONE_NE, 1'b1, NO_COMMAND}},
    '{STEP_SAMPLE, REG_XY_THRESHOLD, 8'h00, '{8'd255, 8'd255}, 1'b1,
      '{1'b1, ZONE_NE, 1'b0, NO_COMMAND}},
    // Opposite corner, then north, north-east, east for two gestures.
    '{STEP_SAMPLE, REG_XY_THRESHOLD, 8'h00, '{8'd0, 8'd0}, 1'b0, UNTYPED},
    '{STEP_SAMPLE, REG_XY_THRESHOLD, 8'h00, '{8'd128, 8'd255}, 1'b0, UNTYPED},
    '{STEP_SAMPLE, REG_XY_THRESHOLD, 8'h00, '{8'd255, 8'd255}, 1'b0, UNTYPED},
    '{STEP_SAMPLE, REG_XY_THRESHOLD, 8'h00, '{8'd255, 8'd128}, 1'b0, UNTYPED},
    // Dead bands on the upper x border and the lower y border.
    '{STEP_SAMPLE, REG_XY_THRESHOLD, 8'h00, '{8'd199, 8'd128}, 1'b0, UNTYPED},
    '{STEP_SAMPLE, REG_XY_THRESHOLD, 8'h00, '{8'd128, 8'd71}, 1'b0, UNTYPED},
    '{STEP_SAMPLE, REG_XY_THRESHOLD, 8'h00, '{8'd128, 8'd0}, 1'b0, UNTYPED},
    '{STEP_SAMPLE, REG_XY_THRESHOLD, 8'h00, '{8'd255, 8'd0}, 1'b0, UNTYPED},
    '{STEP_SAMPLE, REG_XY_THRESHOLD, 8'h00, '{8'd0, 8'd128}, 1'b0, UNTYPED},
    '{STEP_SAMPLE, REG_XY_THRESHOLD, 8'h00, '{8'd0, 8'd255}, 1'b0, UNTYPED},
    '{STEP_SAMPLE, REG_XY_THRESHOLD, 8'h00, '{8'd72, 8'd183}, 1'b0, UNTYPED},
    // Specials off, cardinals off through a masked value, spare indexes.
    '{STEP_WRITE, REG_SPECIAL_MASK, 8'h00, '0, 1'b0, UNTYPED},
    '{STEP_WRITE, REG_ENABLE_CARDINAL, 8'hFE, '0, 1'b0, UNTYPED},
    '{STEP_WRITE, REG_SPARE_LOW, 8'h11, '0, 1'b0, UNTYPED},
    '{STEP_WRITE, REG_SPARE_HIGH, 8'hFF, '0, 1'b0, UNTYPED},
    '{STEP_SAMPLE, REG_XY_THRESHOLD, 8'h00, '{8'd128, 8'd255}, 1'b0, UNTYPED},
    '{STEP_SAMPLE, REG_XY_THRESHOLD, 8'h00, '{8'd0, 8'd255}, 1'b0, UNTYPED},
    // Largest threshold and hysteresis: the borders wrap out of order.
    '{STEP_WRITE, REG_XY_THRESHOLD, 8'hFF, '0, 1'b0, UNTYPED},
    '{STEP_WRITE, REG_HYSTERESIS, 8'hFF, '0, 1'b0, UNTYPED},
    '{STEP_SAMPLE, REG_XY_THRESHOLD, 8'h00, '{8'd129, 8'd129}, 1'b0, UNTYPED},
    '{STEP_SAMPLE, REG_XY_THRESHOLD, 8'h00, '{8'd130, 8'd255}, 1'b0, UNTYPED},
    '{STEP_SAMPLE, REG_XY_THRESHOLD, 8'h00, '{8'd127, 8'd200}, 1'b0, UNTYPED},
    // Zero threshold and hysteresis: all four borders sit at the centre.
    '{STEP_WRITE, REG_XY_THRESHOLD, 8'h00, '0, 1'b0, UNTYPED},
    '{STEP_WRITE, REG_HYSTERESIS, 8'h00, '0, 1'b0, UNTYPED},
    '{STEP_WRITE, REG_ENABLE_CARDINAL, 8'h01, '0, 1'b0, UNTYPED},
    '{STEP_WRITE, REG_ENABLE_DIAGONAL, 8'h00, '0, 1'b0, UNTYPED},
    '{STEP_WRITE, REG_SPECIAL_MASK, 8'hFF, '0, 1'b0, UNTYPED},
    '{STEP_SAMPLE, REG_XY_THRESHOLD, 8'h00, '{8'd127, 8'd127}, 1'b0, UNTYPED},
    '{STEP_SAMPLE, REG_XY_THRESHOLD, 8'h00, '{8'd128, 8'd128}, 1'b0, UNTYPED},
    '{STEP_SAMPLE, REG_XY_THRESHOLD, 8'h00, '{8'd255, 8'd0}, 1'b0, UNTYPED},
    '{STEP_SAMPLE, REG_XY_THRESHOLD, 8'h00, '{8'd0, 8'd255}, 1'b0, UNTYPED}
  };

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_t        in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_t       out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  cfg_idx_t   cfg_index = REG_XY_THRESHOLD;
  logic [7:0] cfg_data  = 8'h00;

  // Mirror of the registers and the zone history, reset values.
  logic [6:0] stick_threshold = 7'd64;
  logic [7:0] dead_width      = 8'd16;
  logic       allow_cardinal  = 1'b1;
  logic       allow_diagonal  = 1'b1;
  logic [7:0] special_mask    = 8'hFF;
  zone_t      zone_hist [3]   = '{ZONE_NEUTRAL, ZONE_NEUTRAL, ZONE_NEUTRAL};
  // Borders in test order: low zone end, low dead end, mid end, high dead end.
  logic [7:0] borders [4];

  out_t pending_gestures [$];
  out_t oldest_gesture;
  int   burst_left;
  int   samples_sent, writes_done, results_checked, pushes_seen, commands_seen;
  int   mismatch_total, stray_results, idle_cycles, long_holds;
  bit   long_hold_request;

  joystick_zone_sequence_matcher_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Borders wrap modulo 256 through the 8-bit arithmetic.
  function automatic void refresh_borders();
    logic [7:0] half;
    half = dead_width >> 1;
    borders[0] = STICK_MID - {1'b0, stick_threshold} - half;
    borders[1] = STICK_MID - {1'b0, stick_threshold} + half;
    borders[2] = STICK_MID + {1'b0, stick_threshold} - half;
    borders[3] = STICK_MID + {1'b0, stick_threshold} + half;
  endfunction

  function automatic segment_e stick_segment(input logic [7:0] v);
    if (v < borders[0]) return SEG_LOW;
    if (v < borders[1]) return SEG_DEAD;
    if (v < borders[2]) return SEG_MID;
    if (v < borders[3]) return SEG_DEAD;
    return SEG_HIGH;
  endfunction

  // Highest enabled gesture that fits the history, oldest entry first.
  function automatic logic [4:0] matched_gesture();
    bit enabled;
    bit fits;
    for (int p = GESTURE_COUNT - 1; p >= 0; p--) begin
      if (p < GROUP_LEN) enabled = allow_cardinal;
      else if (p < 2 * GROUP_LEN) enabled = allow_diagonal;
      else enabled = special_mask[p - 2 * GROUP_LEN];
      fits = 1'b1;
      for (int k = 0; k < 3; k++) begin
        if (GESTURE_SEQ[p][k] != ZONE_NEUTRAL && GESTURE_SEQ[p][k] != zone_hist[k]) fits = 1'b0;
      end
      if (enabled && fits) return 5'(p + 1);
    end
    return NO_COMMAND;
  endfunction

  // Classify one sample, update the history and work out the command.
  function automatic out_t gesture_step(input in_t s);
    segment_e sx;
    segment_e sy;
    out_t     r;
    sx = stick_segment(s.stick_x);
    sy = stick_segment(s.stick_y);
    r = '0;
    if (sx != SEG_DEAD && sy != SEG_DEAD) begin
      r.zone_hit = 1'b1;
      r.zone = ZONE_GRID[sx][sy];
      if (zone_hist[2] != r.zone) begin
        zone_hist[0] = zone_hist[1];
        zone_hist[1] = zone_hist[2];
        zone_hist[2] = r.zone;
        r.history_pushed = 1'b1;
        pushes_seen++;
      end
    end
    r.command = matched_gesture();
    if (r.command != NO_COMMAND) commands_seen++;
    return r;
  endfunction

  // A coordinate in the wanted segment, often close to a border; random if none found.
  function automatic logic [7:0] coord_in(input segment_e want);
    logic [7:0] c;
    c = 8'($urandom);
    for (int tries = 0; tries < 64; tries++) begin
      if (tries % 2 == 1) c = borders[$urandom_range(0, 3)] + 8'($urandom_range(0, 4)) - 8'd2;
      else c = 8'($urandom);
      if (stick_segment(c) == want) return c;
    end
    return c;
  endfunction

  function automatic in_t sample_for_zone(input zone_t z);
    in_t s;
    s = in_t'($urandom);
    for (int ix = 0; ix < 3; ix++) begin
      for (int iy = 0; iy < 3; iy++) begin
        if (ZONE_GRID[ix][iy] == z) begin
          s.stick_x = coord_in(segment_e'(ix));
          s.stick_y = coord_in(segment_e'(iy));
        end
      end
    end
    return s;
  endfunction

  // Offer one sample in bursts with random gaps; record its result on transfer.
  task automatic offer_sample(input in_t s, input logic typed, input out_t typed_result);
    out_t predicted;
    int   gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (in_stall);
    predicted = gesture_step(s);
    pending_gestures.push_back(typed ? typed_result : predicted);
    samples_sent++;
  endtask

  // Stop offering until every result is back, then let the pipeline settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_gestures.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input cfg_idx_t idx, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_XY_THRESHOLD:    stick_threshold = value[6:0];
      REG_HYSTERESIS:      dead_width = value;
      REG_ENABLE_CARDINAL: allow_cardinal = value[0];
      REG_ENABLE_DIAGONAL: allow_diagonal = value[0];
      REG_SPECIAL_MASK:    special_mask = value;
      default: ;
    endcase
    refresh_borders();
    writes_done++;
    @(posedge clk);
  endtask

  // Result side: stall pattern of its own, plus long hold-offs on request.
  initial begin : result_side
    int mode;
    int span;
    wait (rst_n === 1'b1);
    forever begin
      if (long_hold_request) begin
        long_hold_request = 1'b0;
        long_holds++;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(4, 40);
        repeat (span) begin
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= 1'($urandom_range(0, 1));
            default: out_stall <= ($urandom_range(0, 7) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Compare every result transfer with the oldest outstanding prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_gestures.size() == 0) begin
        stray_results++;
        if (stray_results + mismatch_total <= REPORT_LIMIT)
          $display("unexpected result transfer: hit=%0b zone=%0d pushed=%0b cmd=%0d",
                   out_data.zone_hit, out_data.zone, out_data.history_pushed,
                   out_data.command);
      end else begin
        oldest_gesture = pending_gestures.pop_front();
        results_checked++;
        if (out_data.zone_hit !== oldest_gesture.zone_hit ||
            out_data.zone !== oldest_gesture.zone ||
            out_data.history_pushed !== oldest_gesture.history_pushed ||
            out_data.command !== oldest_gesture.command) begin
          mismatch_total++;
          if (stray_results + mismatch_total <= REPORT_LIMIT)
            $display("result %0d: expected hit=%0b zone=%0d pushed=%0b cmd=%0d, got %0b %0d %0b %0d",
                     results_checked, oldest_gesture.zone_hit, oldest_gesture.zone,
                     oldest_gesture.history_pushed, oldest_gesture.command,
                     out_data.zone_hit, out_data.zone, out_data.history_pushed,
                     out_data.command);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_joystick_zone_sequence_matcher_unit failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int         phase_items;
    int         gi;
    int         len;
    int         reps;
    int         pick;
    bit         hold_armed;
    bit         pause_armed;
    zone_t      z;
    in_t        s;
    logic [7:0] noise_bits;
    logic [6:0] thr_v;
    logic [7:0] hyst_v;
    logic [7:0] mask_v;
    logic       card_v;
    logic       diag_v;
    refresh_borders();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed plan.
    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (DIRECTED_PLAN[r].kind == STEP_WRITE) begin
        wait_idle();
        write_register(DIRECTED_PLAN[r].reg_index, DIRECTED_PLAN[r].reg_value);
      end else begin
        offer_sample(DIRECTED_PLAN[r].sample, DIRECTED_PLAN[r].typed,
                     DIRECTED_PLAN[r].result);
      end
    end

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      wait_idle();
      case (ph)
        0: begin thr_v = 7'd64;  hyst_v = 8'd16;  card_v = 1'b1; diag_v = 1'b1; mask_v = 8'hFF; end
        1: begin thr_v = 7'd0;   hyst_v = 8'd0;   card_v = 1'b1; diag_v = 1'b1; mask_v = 8'hFF; end
        2: begin thr_v = 7'd127; hyst_v = 8'd255; card_v = 1'b1; diag_v = 1'b1; mask_v = 8'hFF; end
        3: begin thr_v = 7'd127; hyst_v = 8'd0;   card_v = 1'b0; diag_v = 1'b1; mask_v = 8'h55; end
        4: begin thr_v = 7'd20;  hyst_v = 8'd200; card_v = 1'b1; diag_v = 1'b0; mask_v = 8'hAA; end
        5: begin thr_v = 7'd100; hyst_v = 8'd40;  card_v = 1'b0; diag_v = 1'b0; mask_v = 8'h0F; end
        default: begin
          thr_v  = 7'($urandom);
          hyst_v = 8'($urandom);
          card_v = 1'($urandom);
          diag_v = 1'($urandom);
          mask_v = 8'($urandom);
        end
      endcase
      // Upper bits of narrow registers carry noise that must be dropped.
      noise_bits = 8'($urandom);
      write_register(REG_XY_THRESHOLD, {noise_bits[7], thr_v});
      write_register(REG_HYSTERESIS, hyst_v);
      write_register(REG_ENABLE_CARDINAL, {noise_bits[6:0], card_v});
      write_register(REG_ENABLE_DIAGONAL, {noise_bits[7:1], diag_v});
      write_register(REG_SPECIAL_MASK, mask_v);
      if (noise_bits[0]) write_register(REG_SPARE_HIGH, 8'($urandom));

      hold_armed  = (ph == 2 || ph == 5);
      pause_armed = (ph == 3);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
          // Plain noise.
          offer_sample(in_t'($urandom), 1'b0, UNTYPED);
          phase_items++;
        end else begin
          // A gesture, sometimes cut short, with repeats and dead-band samples.
          gi  = $urandom_range(0, GESTURE_COUNT - 1);
          len = (pick < 4) ? $urandom_range(1, 2) : 3;
          for (int k = 0; k < len; k++) begin
            z = GESTURE_SEQ[gi][k];
            if (z == ZONE_NEUTRAL) z = zone_t'($urandom_range(ZONE_NEUTRAL, ZONE_NW));
            reps = $urandom_range(1, 3);
            for (int n = 0; n < reps; n++) begin
              if ($urandom_range(0, 5) == 0) begin
                s = in_t'($urandom);
                if ($urandom_range(0, 1) == 1) s.stick_x = coord_in(SEG_DEAD);
                else s.stick_y = coord_in(SEG_DEAD);
                offer_sample(s, 1'b0, UNTYPED);
                phase_items++;
              end
              offer_sample(sample_for_zone(z), 1'b0, UNTYPED);
              phase_items++;
            end
          end
        end
        // Long result hold-off while samples keep coming, so the input backs up.
        if (hold_armed && phase_items >= 40) begin
          long_hold_request = 1'b1;
          hold_armed = 1'b0;
        end
        if (pause_armed && phase_items >= 60) begin
          wait_idle();
          pause_armed = 1'b0;
        end
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    $display("Covered %0d stick samples and %0d register writes over %0d random settings.",
             samples_sent, writes_done, PHASE_COUNT);
    $display("Checked %0d results: %0d history pushes, %0d matched commands, %0d long holds.",
             results_checked, pushes_seen, commands_seen, long_holds);
    if (mismatch_total == 0 && stray_results == 0 && pending_gestures.size() == 0) begin
      $display("tb_joystick_zone_sequence_matcher_unit passed");
    end else begin
      $display("tb_joystick_zone_sequence_matcher_unit failed");
    end
    $finish;
  end

endmodule
